@@ design/sld_pkg.sv @@
// Shared types and constants for the sync/length/checksum deframer.
`default_nettype none
package sld_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT  = 2'd1;

    // Register reset values
    localparam logic [31:0] START_PATTERN_RST = 32'h1395_6563;
    localparam logic [15:0] LENGTH_LIMIT_RST  = 16'd16182;

    localparam int unsigned START_BYTES = 4;

    // Status event codes
    localparam logic [2:0] EV_HUNT     = 3'd0;
    localparam logic [2:0] EV_HDR_OK   = 3'd1;
    localparam logic [2:0] EV_PAYLOAD  = 3'd2;
    localparam logic [2:0] EV_GOOD     = 3'd3;
    localparam logic [2:0] EV_BAD      = 3'd4;
    localparam logic [2:0] EV_LEN_REJ  = 3'd5;

    typedef struct packed {
        logic [31:0] start_pattern;
        logic [15:0] length_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [15:0] frame_length;
        logic [15:0] payload_index;
    } result_t;

endpackage
`default_nettype wire

@@ design/sld_cfg_regs.sv @@
// Configuration register file: start pattern and length limit.
`default_nettype none
module sld_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sld_pkg::CFG_DATA_W-1:0] cfg_data,
    output sld_pkg::cfg_t                      cfg
);

    logic [31:0] start_pattern_reg;
    logic [15:0] length_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pattern_reg <= sld_pkg::START_PATTERN_RST;
            length_limit_reg  <= sld_pkg::LENGTH_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sld_pkg::CFG_START_PATTERN: start_pattern_reg <= cfg_data[31:0];
                sld_pkg::CFG_LENGTH_LIMIT:  length_limit_reg  <= cfg_data[15:0];
                default: ; // unmapped index: ignored
            endcase
        end
    end

    assign cfg.start_pattern = start_pattern_reg;
    assign cfg.length_limit  = length_limit_reg;

endmodule
`default_nettype wire

@@ design/sld_core.sv @@
// Deframer state machine: hunt, length, payload/checksum; one byte per step.
`default_nettype none
module sld_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    input  wire sld_pkg::cfg_t cfg,
    output sld_pkg::result_t result
);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_LEN_HI = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    localparam logic [1:0] LAST_MATCH = 2'(sld_pkg::START_BYTES - 1);

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  match_count_reg, match_count_next;
    logic [15:0] declared_length_reg, declared_length_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [2:0]  ev;
    logic [7:0]  expect_byte;
    logic [15:0] len_full;

    always_comb
    begin
        case (match_count_reg)
            2'd0:    expect_byte = cfg.start_pattern[7:0];
            2'd1:    expect_byte = cfg.start_pattern[15:8];
            2'd2:    expect_byte = cfg.start_pattern[23:16];
            default: expect_byte = cfg.start_pattern[31:24];
        endcase
    end

    assign len_full = {rx_byte, declared_length_reg[7:0]};

    always_comb
    begin
        phase_next           = phase_reg;
        match_count_next     = match_count_reg;
        declared_length_next = declared_length_reg;
        byte_count_next      = byte_count_reg;
        running_sum_next     = running_sum_reg;
        ev                   = sld_pkg::EV_HUNT;
        case (phase_reg)
            PH_HUNT:
            begin
                // a mismatch just restarts the count; the byte is not retried
                if (rx_byte == expect_byte)
                begin
                    if (match_count_reg == LAST_MATCH)
                    begin
                        phase_next       = PH_LEN_LO;
                        match_count_next = 2'd0;
                    end
                    else
                    begin
                        match_count_next = match_count_reg + 2'd1;
                    end
                end
                else
                begin
                    match_count_next = 2'd0;
                end
            end
            PH_LEN_LO:
            begin
                declared_length_next = {8'd0, rx_byte};
                phase_next           = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                declared_length_next = len_full;
                if (len_full >= cfg.length_limit)
                begin
                    phase_next = PH_HUNT;
                    ev         = sld_pkg::EV_LEN_REJ;
                end
                else
                begin
                    phase_next       = PH_DATA;
                    byte_count_next  = 16'd0;
                    running_sum_next = 8'd0;
                    ev               = sld_pkg::EV_HDR_OK;
                end
            end
            default:
            begin
                if (byte_count_reg == declared_length_reg)
                begin
                    ev = (running_sum_reg == rx_byte) ? sld_pkg::EV_GOOD : sld_pkg::EV_BAD;
                    phase_next = PH_HUNT;
                end
                else
                begin
                    running_sum_next = running_sum_reg + rx_byte;
                    byte_count_next  = byte_count_reg + 16'd1;
                    ev               = sld_pkg::EV_PAYLOAD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HUNT;
            match_count_reg     <= 2'd0;
            declared_length_reg <= 16'd0;
            byte_count_reg      <= 16'd0;
            running_sum_reg     <= 8'd0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            match_count_reg     <= match_count_next;
            declared_length_reg <= declared_length_next;
            byte_count_reg      <= byte_count_next;
            running_sum_reg     <= running_sum_next;
        end
    end

    assign result.event_res     = ev;
    assign result.data_byte     = rx_byte;
    assign result.frame_length  = declared_length_next;
    assign result.payload_index = byte_count_next;

    // match count only runs while hunting
    a_match_only_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_HUNT |-> match_count_reg == 2'd0)
        else $error("match count nonzero outside hunt");

    // payload count never passes the declared length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> byte_count_reg <= declared_length_reg)
        else $error("payload count past declared length");

    // accepted header opens a fresh payload
    a_hdr_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && ev == sld_pkg::EV_HDR_OK |=> phase_reg == PH_DATA && byte_count_reg == 16'd0
            && running_sum_reg == 8'd0)
        else $error("header accept did not start payload");

    // rejected length returns to hunting
    a_rej_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        step && ev == sld_pkg::EV_LEN_REJ |=> phase_reg == PH_HUNT)
        else $error("length reject did not return to hunt");

    // checksum verdicts only come from the payload phase
    a_verdict_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step && (ev == sld_pkg::EV_GOOD || ev == sld_pkg::EV_BAD) |-> phase_reg == PH_DATA)
        else $error("checksum verdict outside payload phase");

endmodule
`default_nettype wire

@@ design/sync_length_checksum_deframer.sv @@
// Top level of the sync/length/checksum deframer: input register, core, result register.
`default_nettype none
// Byte-stream deframer. Each accepted rx_byte request yields exactly one
// status request: hunting, header accepted, payload byte, frame good,
// checksum bad or length rejected, with the byte echoed and the current
// declared length and payload count. Throughput is one byte per clock
// while out_stall is low; an accepted byte is held in the input register,
// passes the core's state update and is captured in the result register.
// The input side keeps accepting while a result waits on a stalled output,
// until both registers are full. Configuration (start pattern at index 0,
// length limit at index 1) is written through cfg_we/cfg_index/cfg_data;
// other indexes are ignored. Write it only while the block is idle.
module sync_length_checksum_deframer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    rx_byte,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         event_res,
    output logic [7:0]                         data_byte,
    output logic [15:0]                        frame_length,
    output logic [15:0]                        payload_index,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [sld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sld_pkg::CFG_DATA_W-1:0] cfg_data
);

    sld_pkg::cfg_t    cfg;
    sld_pkg::result_t core_result;
    sld_pkg::result_t out_reg;

    logic       in_full_reg, in_full_next;
    logic [7:0] rx_reg;
    logic       out_valid_reg, out_valid_next;
    logic       advance;
    logic       in_take;

    sld_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the held byte moves to the result register when that slot frees up
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign in_full_next   = in_take || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    sld_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (rx_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rx_reg <= rx_byte;
        end
        if (advance)
        begin
            out_reg <= core_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = out_reg.event_res;
    assign data_byte     = out_reg.data_byte;
    assign frame_length  = out_reg.frame_length;
    assign payload_index = out_reg.payload_index;

    // core only steps with a byte in hand
    a_step_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> in_full_reg)
        else $error("core stepped without input byte");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !advance)
        else $error("result overwritten while stalled");

    // a result shows up in the cycle after the core steps
    a_step_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && out_reg.data_byte == $past(rx_reg))
        else $error("stepped byte missing from result register");

endmodule
`default_nettype wire
